### hw/rtl/tcce_pkg.sv
// Package for the text console character engine: geometry, field widths,
// character codes, operation codes, controller states and the command/status structs.
// Depends on nothing; every other file of the block but tcce_ram imports it.
package tcce_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int PTR_W       = $clog2(CELL_COUNT + 1);

    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int OFFSET_W = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [ATTR_W-1:0] COLOUR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET   = 16'h0F20;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam int TAB_STOP = 8;
    localparam logic [COL_W:0] TAB_MASK = ~((COL_W + 1)'(TAB_STOP - 1));

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 3'd0,
        OP_MARK  = 3'd1,
        OP_SET   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } tcce_op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_SCROLL,
        ST_FILL
    } tcce_state_t;

    // What an executed operation still needs after its first cycle
    typedef enum logic [2:0] {
        FOLLOW_NONE,
        FOLLOW_READ,
        FOLLOW_SCAN,
        FOLLOW_SCROLL,
        FOLLOW_FILL
    } tcce_follow_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic push;
        logic push_cell;
        logic scan_read;
        logic scan_step;
        logic scan_finish;
        logic scroll_step;
        logic fill_load;
        logic fill_step;
        logic fill_init;
    } tcce_cmd_t;

    typedef struct packed {
        tcce_follow_t follow;
        logic         scan_at_zero;
        logic         scan_space;
        logic         scroll_done;
        logic         fill_last;
    } tcce_stat_t;

    typedef struct packed {
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
        logic [OFFSET_W-1:0] cursor_offset;
        logic [CELL_W-1:0]   cell_data;
        logic                before_input_start;
        logic                request_ignored;
    } tcce_result_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * SCREEN_COLS + int'(col));
    endfunction

    function automatic logic [OFFSET_W-1:0] linear_offset(input logic [ROW_W-1:0] row,
                                                          input logic [COL_W-1:0] col);
        return OFFSET_W'(int'(row) * SCREEN_COLS + int'(col));
    endfunction

endpackage

### hw/rtl/tcce_if.sv
// Channel interfaces of the text console engine: operation requests and results.
// Depends on tcce_pkg for field widths.
interface tcce_op_if;
    import tcce_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;

    modport source (output valid, op, char_code, target_col, target_row, input ready);
    modport sink   (input valid, op, char_code, target_col, target_row, output ready);
endinterface

interface tcce_result_if;
    import tcce_pkg::*;

    logic                valid;
    logic                ready;
    logic [COL_W-1:0]    cursor_col;
    logic [ROW_W-1:0]    cursor_row;
    logic [OFFSET_W-1:0] cursor_offset;
    logic [CELL_W-1:0]   cell_data;
    logic                before_input_start;
    logic                request_ignored;

    modport source (output valid, cursor_col, cursor_row, cursor_offset, cell_data,
                    before_input_start, request_ignored, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_offset, cell_data,
                    before_input_start, request_ignored, output ready);
endinterface

### hw/rtl/text_console_char_engine_core.sv
// Text console engine top level: request/result channels, APB colour register,
// controller, datapath and cell store. Depends on tcce_pkg, tcce_if, tcce_ram,
// tcce_ctrl and tcce_datapath.
// Results are registered. A cell read waits for the store's registered read data; a
// backspace may walk back along the previous row, and a scroll or a clear sweeps
// the store through its single port pair.
// A new request is taken only in idle, once the previous one has pushed its result.
// Reset: asynchronous, active low; afterwards a clearing pass writes CELL_RESET to
// all CELL_COUNT cells (2000 at 80x25) of the store while op_chan.ready stays low.
module text_console_char_engine_core (
    input  logic                            clk,
    input  logic                            rst_n,
    tcce_op_if.sink                         op_chan,
    tcce_result_if.source                   result_chan,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcce_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tcce_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tcce_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tcce_pkg::*;

    logic [ATTR_W-1:0] colour_reg, colour_next;
    logic              cfg_write;
    logic              colour_sel;

    tcce_cmd_t         cmd;
    tcce_stat_t        stat;
    tcce_result_t      result;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // APB: zero wait states; the colour register sits at byte address 0, the
    // low two address bits are ignored, addresses 4 and up read zero and drop writes
    assign pready     = 1'b1;
    assign colour_sel = !paddr[APB_ADDR_W-1];
    assign cfg_write  = psel && penable && pwrite && colour_sel;
    assign colour_next = cfg_write ? pwdata[ATTR_W-1:0] : colour_reg;
    assign prdata     = colour_sel ? APB_DATA_W'(colour_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg <= COLOUR_RESET;
        end
        else
        begin
            colour_reg <= colour_next;
        end
    end

    // Controller: owns handshakes and sequences each operation through
    // execute, read wait, backspace row walk, scroll copy and blank fill
    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op_chan.valid),
        .in_ready  (op_chan.ready),
        .out_valid (result_chan.valid),
        .out_ready (result_chan.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: cursor, mark, sweep pointer, store addressing and the result register
    tcce_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op_chan.op),
        .char_code   (op_chan.char_code),
        .target_col  (op_chan.target_col),
        .target_row  (op_chan.target_row),
        .text_colour (colour_reg),
        .cmd         (cmd),
        .stat        (stat),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .result      (result)
    );

    // Cell store: character in the low byte, attribute in the high byte
    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result_chan.cursor_col         = result.cursor_col;
    assign result_chan.cursor_row         = result.cursor_row;
    assign result_chan.cursor_offset      = result.cursor_offset;
    assign result_chan.cell_data          = result.cell_data;
    assign result_chan.before_input_start = result.before_input_start;
    assign result_chan.request_ignored    = result.request_ignored;
endmodule

### hw/rtl/tcce_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/tcce_ctrl.sv
// Controller of the text console engine: sequences each operation and owns the
// channel handshakes. Depends on tcce_pkg (states, command and status structs).
module tcce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tcce_pkg::tcce_stat_t stat,
    output tcce_pkg::tcce_cmd_t  cmd
);
    import tcce_pkg::*;

    tcce_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_step = 1'b1;
                cmd.fill_init = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result slot is free so later pushes never collide
                if (out_free)
                begin
                    cmd.exec = 1'b1;
                    case (stat.follow)
                        FOLLOW_NONE:
                        begin
                            cmd.push   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        FOLLOW_READ:   state_next = ST_READ;
                        FOLLOW_SCAN:   state_next = ST_SCAN_RD;
                        FOLLOW_SCROLL: state_next = ST_SCROLL;
                        FOLLOW_FILL:   state_next = ST_FILL;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.push      = 1'b1;
                cmd.push_cell = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                if (stat.scan_at_zero)
                begin
                    cmd.scan_finish = 1'b1;
                    cmd.push        = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.scan_read = 1'b1;
                    state_next    = ST_SCAN_CK;
                end
            end
            ST_SCAN_CK:
            begin
                if (stat.scan_space)
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
                else
                begin
                    cmd.scan_finish = 1'b1;
                    cmd.push        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                if (stat.scroll_done)
                begin
                    cmd.fill_load = 1'b1;
                    state_next    = ST_FILL;
                end
                else
                begin
                    cmd.scroll_step = 1'b1;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

### hw/rtl/tcce_datapath.sv
// Datapath of the text console engine: cursor and mark registers, item latch,
// store address generation, sweep pointer and result register. Depends on tcce_pkg.
module tcce_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcce_pkg::OP_W-1:0]     op,
    input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcce_pkg::COL_W-1:0]    target_col,
    input  logic [tcce_pkg::ROW_W-1:0]    target_row,
    input  logic [tcce_pkg::ATTR_W-1:0]   text_colour,
    input  tcce_pkg::tcce_cmd_t           cmd,
    output tcce_pkg::tcce_stat_t          stat,
    output logic                          ram_we,
    output logic [tcce_pkg::ADDR_W-1:0]   ram_waddr,
    output logic [tcce_pkg::CELL_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [tcce_pkg::ADDR_W-1:0]   ram_raddr,
    input  logic [tcce_pkg::CELL_W-1:0]   ram_rdata,
    output tcce_pkg::tcce_result_t        result
);
    import tcce_pkg::*;

    // item latch (payload, no reset)
    logic [OP_W-1:0]   op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [COL_W-1:0]  tc_reg;
    logic [ROW_W-1:0]  tr_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  mark_col_reg, mark_col_next;
    logic [ROW_W-1:0]  mark_row_reg, mark_row_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    tcce_result_t      result_reg, result_next;

    logic              in_range;
    logic [CELL_W-1:0] blank;
    logic [COL_W:0]    col_w;
    logic [ROW_W:0]    row_w;
    logic              put_we;
    logic [ADDR_W-1:0] put_addr;
    logic [CELL_W-1:0] put_data;
    logic              scan_go;
    logic              scroll_go;
    logic              bs_allowed;
    logic [COL_W:0]    col_inc;
    logic              ptr_at_end;

    assign in_range   = (int'(tc_reg) < SCREEN_COLS) && (int'(tr_reg) < SCREEN_ROWS);
    assign blank      = {text_colour, CH_SPACE};
    assign ptr_at_end = (ptr_reg == PTR_W'(CELL_COUNT));
    assign bs_allowed = (row_reg > mark_row_reg) ||
                        ((row_reg == mark_row_reg) && ((col_reg - 1'b1) >= mark_col_reg));

    // put-character cursor movement, before the scroll fold
    always_comb
    begin
        col_w    = {1'b0, col_reg};
        row_w    = {1'b0, row_reg};
        put_we   = 1'b0;
        put_addr = cell_addr(row_reg, col_reg);
        put_data = {text_colour, ch_reg};
        scan_go  = 1'b0;
        case (ch_reg)
            CH_LF:
            begin
                col_w = '0;
                row_w = row_w + 1'b1;
            end
            CH_CR:
            begin
                col_w = '0;
            end
            CH_TAB:
            begin
                col_w = (col_w + (COL_W + 1)'(TAB_STOP)) & TAB_MASK;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    if (bs_allowed)
                    begin
                        col_w    = col_w - 1'b1;
                        put_we   = 1'b1;
                        put_addr = cell_addr(row_reg, col_reg - 1'b1);
                        put_data = blank;
                    end
                end
                else if ((row_reg != '0) && (row_reg > mark_row_reg))
                begin
                    // drop to the previous row and scan back for its last character
                    scan_go = 1'b1;
                    row_w   = row_w - 1'b1;
                    col_w   = (COL_W + 1)'(SCREEN_COLS - 1);
                end
            end
            default:
            begin
                put_we = 1'b1;
                col_w  = col_w + 1'b1;
            end
        endcase
        if (int'(col_w) >= SCREEN_COLS)
        begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end
        scroll_go = (int'(row_w) >= SCREEN_ROWS);
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        mark_col_next = mark_col_reg;
        mark_row_next = mark_row_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        waddr_next    = waddr_reg;
        ram_we        = 1'b0;
        ram_waddr     = put_addr;
        ram_wdata     = put_data;
        ram_re        = 1'b0;
        ram_raddr     = cell_addr(row_reg, col_reg);
        col_inc       = {1'b0, col_reg} + 1'b1;
        stat.follow   = FOLLOW_NONE;

        stat.scan_at_zero = (col_reg == '0);
        stat.scan_space   = (ram_rdata[CHAR_W-1:0] == CH_SPACE);
        stat.scroll_done  = ptr_at_end && !pend_reg;
        stat.fill_last    = (ptr_reg == PTR_W'(CELL_COUNT - 1));

        case (op_reg)
            OP_PUT:
            begin
                if (scan_go)
                begin
                    stat.follow = FOLLOW_SCAN;
                end
                else if (scroll_go)
                begin
                    stat.follow = FOLLOW_SCROLL;
                end
            end
            OP_CLEAR: stat.follow = FOLLOW_FILL;
            OP_READ:
            begin
                if (in_range)
                begin
                    stat.follow = FOLLOW_READ;
                end
            end
            default: stat.follow = FOLLOW_NONE;
        endcase

        if (cmd.exec)
        begin
            case (op_reg)
                OP_PUT:
                begin
                    ram_we   = put_we;
                    col_next = col_w[COL_W-1:0];
                    if (scroll_go)
                    begin
                        row_next  = ROW_W'(SCREEN_ROWS - 1);
                        ptr_next  = PTR_W'(SCREEN_COLS);
                        pend_next = 1'b0;
                        if (mark_row_reg != '0)
                        begin
                            mark_row_next = mark_row_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        row_next = row_w[ROW_W-1:0];
                    end
                end
                OP_MARK:
                begin
                    mark_col_next = col_reg;
                    mark_row_next = row_reg;
                end
                OP_SET:
                begin
                    if (in_range)
                    begin
                        col_next = tc_reg;
                        row_next = tr_reg;
                    end
                end
                OP_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                    ptr_next = '0;
                end
                OP_READ:
                begin
                    ram_re    = in_range;
                    ram_raddr = cell_addr(tr_reg, tc_reg);
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end

        if (cmd.scan_read)
        begin
            ram_re = 1'b1;
        end
        if (cmd.scan_step)
        begin
            col_next = col_reg - 1'b1;
        end
        if (cmd.scan_finish)
        begin
            if (int'(col_inc) >= SCREEN_COLS)
            begin
                col_inc = (COL_W + 1)'(SCREEN_COLS - 1);
            end
            if ((row_reg == mark_row_reg) && (col_inc < {1'b0, mark_col_reg}))
            begin
                col_inc = {1'b0, mark_col_reg};
            end
            col_next = col_inc[COL_W-1:0];
        end

        // scroll: read cell i, write it one row up on the next cycle
        if (cmd.scroll_step)
        begin
            ram_raddr  = ptr_reg[ADDR_W-1:0];
            ram_re     = !ptr_at_end;
            ram_we     = pend_reg;
            ram_waddr  = waddr_reg;
            ram_wdata  = ram_rdata;
            pend_next  = !ptr_at_end;
            waddr_next = ADDR_W'(ptr_reg - PTR_W'(SCREEN_COLS));
            if (!ptr_at_end)
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
        if (cmd.fill_load)
        begin
            ptr_next = PTR_W'((SCREEN_ROWS - 1) * SCREEN_COLS);
        end
        if (cmd.fill_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg[ADDR_W-1:0];
            ram_wdata = cmd.fill_init ? CELL_RESET : blank;
            ptr_next  = ptr_reg + 1'b1;
        end
    end

    // result reflects the state as it stands after this cycle
    always_comb
    begin
        result_next.cursor_col         = col_next;
        result_next.cursor_row         = row_next;
        result_next.cursor_offset      = linear_offset(row_next, col_next);
        result_next.cell_data          = cmd.push_cell ? ram_rdata : '0;
        result_next.before_input_start = (row_next < mark_row_next) ||
                                         ((row_next == mark_row_next) &&
                                          (col_next <= mark_col_next));
        result_next.request_ignored    = ((op_reg == OP_SET) || (op_reg == OP_READ)) &&
                                         !in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            mark_col_reg <= '0;
            mark_row_reg <= '0;
            ptr_reg      <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            mark_col_reg <= mark_col_next;
            mark_row_reg <= mark_row_next;
            ptr_reg      <= ptr_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg <= waddr_next;
        if (cmd.load_item)
        begin
            op_reg <= op;
            ch_reg <= char_code;
            tc_reg <= target_col;
            tr_reg <= target_row;
        end
        if (cmd.push)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
endmodule

### hw/rtl/tcce_checker.sv
// Port-level checker for the text console engine and its bind to the top level.
// Depends on tcce_pkg and text_console_char_engine_core.
module tcce_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          valid,
    input logic                          ready,
    input logic [tcce_pkg::COL_W-1:0]    cursor_col,
    input logic [tcce_pkg::ROW_W-1:0]    cursor_row,
    input logic [tcce_pkg::OFFSET_W-1:0] cursor_offset,
    input logic [tcce_pkg::CELL_W-1:0]   cell_data,
    input logic                          request_ignored
);
    import tcce_pkg::*;

    // hold a stalled result until it is taken
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped while stalled");

    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> cursor_offset == linear_offset(cursor_row, cursor_col))
        else $error("cursor offset does not match cursor");

    a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (int'(cursor_col) < SCREEN_COLS) && (int'(cursor_row) < SCREEN_ROWS))
        else $error("cursor off screen");

    a_ignored_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        valid && request_ignored |-> cell_data == '0)
        else $error("ignored request returned cell data");
endmodule

bind text_console_char_engine_core tcce_checker u_tcce_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid           (result_chan.valid),
    .ready           (result_chan.ready),
    .cursor_col      (result_chan.cursor_col),
    .cursor_row      (result_chan.cursor_row),
    .cursor_offset   (result_chan.cursor_offset),
    .cell_data       (result_chan.cell_data),
    .request_ignored (result_chan.request_ignored)
);
